>>> rtl/core/assert_macros.svh
// Assertion macros for the checker file of this block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is held
`define BPBB_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also runs through reset
`define BPBB_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/bpbb_pkg.sv
// Shared constants, register map and types of the bright pixel bounding box
package bpbb_pkg;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int DEF_FRAC_BITS  = 16;

  localparam int PIX_W      = 8;
  localparam int CFG_SIZE_W = 13;
  localparam int CFG_THR_W  = 8;
  localparam int CFG_AW     = 4;
  localparam int CFG_DW     = 32;
  localparam int FRAC_OUT_W = 16;
  localparam int N_EDGES    = 4;
  localparam int OUT_DATA_W = N_EDGES * FRAC_OUT_W;
  localparam int Q_DEPTH    = 2;

  localparam logic [CFG_SIZE_W-1:0] RST_WIDTH  = 13'd640;
  localparam logic [CFG_SIZE_W-1:0] RST_HEIGHT = 13'd480;
  localparam logic [CFG_THR_W-1:0]  RST_THRESH = 8'd128;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_THRESH = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

>>> rtl/core/bpbb_front.sv
// Front end: pixel position tracking, threshold test and bounding box update
module bpbb_front #(
  parameter int MAX_WIDTH  = bpbb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bpbb_pkg::DEF_MAX_HEIGHT,
  localparam int PWW   = $clog2(MAX_WIDTH),
  localparam int PWH   = $clog2(MAX_HEIGHT),
  localparam int SWW   = $clog2(MAX_WIDTH + 1),
  localparam int SWH   = $clog2(MAX_HEIGHT + 1),
  localparam int JOB_W = 1 + 2 * PWW + 2 * PWH + SWW + SWH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [bpbb_pkg::PIX_W-1:0]       in_pixel,
  input  logic                             in_start,
  input  logic [bpbb_pkg::CFG_SIZE_W-1:0]  cfg_width,
  input  logic [bpbb_pkg::CFG_SIZE_W-1:0]  cfg_height,
  input  logic [bpbb_pkg::CFG_THR_W-1:0]   cfg_thresh,
  input  bpbb_pkg::q_stat_t                q_stat,
  output logic                             job_wr,
  output logic [JOB_W-1:0]                 job_data
);
  import bpbb_pkg::*;

  logic [PWW-1:0] col_r, col_nxt, min_c_r, min_c_nxt, max_c_r, max_c_nxt;
  logic [PWH-1:0] row_r, row_nxt, min_r_r, min_r_nxt, max_r_r, max_r_nxt;
  logic           any_r, any_nxt;

  logic [PWW-1:0] cur_col, n_min_c, n_max_c;
  logic [PWH-1:0] cur_row, n_min_r, n_max_r;
  logic           cur_any, n_any, bright, col_more, row_more, accept;
  logic [SWW-1:0] w_eff;
  logic [SWH-1:0] h_eff;

  // zero acts as one, oversize acts as the maximum
  always_comb begin
    if (cfg_width == '0) w_eff = SWW'(1);
    else if (32'(cfg_width) > 32'(MAX_WIDTH)) w_eff = SWW'(MAX_WIDTH);
    else w_eff = SWW'(cfg_width);
    if (cfg_height == '0) h_eff = SWH'(1);
    else if (32'(cfg_height) > 32'(MAX_HEIGHT)) h_eff = SWH'(MAX_HEIGHT);
    else h_eff = SWH'(cfg_height);
  end

  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;

  assign cur_col = in_start ? '0 : col_r;
  assign cur_row = in_start ? '0 : row_r;
  assign cur_any = in_start ? 1'b0 : any_r;
  assign bright  = in_pixel > cfg_thresh;

  always_comb begin
    n_min_c = min_c_r;
    n_max_c = max_c_r;
    n_min_r = min_r_r;
    n_max_r = max_r_r;
    n_any   = cur_any;
    if (bright && !cur_any) begin
      n_min_c = cur_col;
      n_max_c = cur_col;
      n_min_r = cur_row;
      n_max_r = cur_row;
      n_any   = 1'b1;
    end else if (bright) begin
      if (cur_col < min_c_r) n_min_c = cur_col;
      if (cur_col > max_c_r) n_max_c = cur_col;
      if (cur_row < min_r_r) n_min_r = cur_row;
      if (cur_row > max_r_r) n_max_r = cur_row;
    end
  end

  assign col_more = (32'(cur_col) + 32'd1) < 32'(w_eff);
  assign row_more = (32'(cur_row) + 32'd1) < 32'(h_eff);

  assign job_wr   = accept && !col_more && !row_more;
  assign job_data = {n_any, n_min_c, n_max_c, n_min_r, n_max_r, w_eff, h_eff};

  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    min_c_nxt = min_c_r;
    max_c_nxt = max_c_r;
    min_r_nxt = min_r_r;
    max_r_nxt = max_r_r;
    any_nxt   = any_r;
    if (accept) begin
      min_c_nxt = n_min_c;
      max_c_nxt = n_max_c;
      min_r_nxt = n_min_r;
      max_r_nxt = n_max_r;
      any_nxt   = n_any;
      priority if (col_more) begin
        col_nxt = cur_col + 1'b1;
        row_nxt = cur_row;
      end else if (row_more) begin
        col_nxt = '0;
        row_nxt = cur_row + 1'b1;
      end else begin
        // frame done: box handed off, start clean
        col_nxt   = '0;
        row_nxt   = '0;
        min_c_nxt = '1;
        max_c_nxt = '0;
        min_r_nxt = '1;
        max_r_nxt = '0;
        any_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      min_c_r <= '1;
      max_c_r <= '0;
      min_r_r <= '1;
      max_r_r <= '0;
      any_r   <= 1'b0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      min_c_r <= min_c_nxt;
      max_c_r <= max_c_nxt;
      min_r_r <= min_r_nxt;
      max_r_r <= max_r_nxt;
      any_r   <= any_nxt;
    end
  end

endmodule

>>> rtl/core/bpbb_queue.sv
// Short job queue between the front end and the divider back end
module bpbb_queue #(
  parameter int DW = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic [DW-1:0]      wr_data,
  input  logic               rd_en,
  output logic [DW-1:0]      rd_data,
  output bpbb_pkg::q_stat_t  stat
);
  import bpbb_pkg::*;

  localparam int QAW = $clog2(Q_DEPTH);

  logic [DW-1:0]  mem_r [Q_DEPTH];
  logic [QAW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           do_wr, do_rd;

  assign stat.full  = cnt_r == (QAW+1)'(Q_DEPTH);
  assign stat.empty = cnt_r == '0;
  assign do_wr      = wr_en && !stat.full;
  assign do_rd      = rd_en && !stat.empty;
  assign rd_data    = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) wp_nxt = (wp_r == QAW'(Q_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    if (do_rd) rp_nxt = (rp_r == QAW'(Q_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    if (do_wr && !do_rd) cnt_nxt = cnt_r + 1'b1;
    else if (do_rd && !do_wr) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> rtl/core/bpbb_back.sv
// Back end: shared radix-2 divider for the four box edges, result register
module bpbb_back #(
  parameter int MAX_WIDTH  = bpbb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bpbb_pkg::DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = bpbb_pkg::DEF_FRAC_BITS,
  localparam int PWW   = $clog2(MAX_WIDTH),
  localparam int PWH   = $clog2(MAX_HEIGHT),
  localparam int SWW   = $clog2(MAX_WIDTH + 1),
  localparam int SWH   = $clog2(MAX_HEIGHT + 1),
  localparam int JOB_W = 1 + 2 * PWW + 2 * PWH + SWW + SWH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  bpbb_pkg::q_stat_t                q_stat,
  input  logic [JOB_W-1:0]                 q_data,
  output logic                             q_rd,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [bpbb_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [0:0]                       out_tuser
);
  import bpbb_pkg::*;

  localparam int PW  = (PWW > PWH) ? PWW : PWH;
  localparam int SW  = (SWW > SWH) ? SWW : SWH;
  localparam int NW  = PW + FRAC_BITS;
  localparam int STW = $clog2(NW);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } back_state_t;

  typedef enum logic [1:0] {
    EDGE_LEFT   = 2'd0,
    EDGE_RIGHT  = 2'd1,
    EDGE_TOP    = 2'd2,
    EDGE_BOTTOM = 2'd3
  } edge_idx_t;

  back_state_t            state_r, state_nxt;
  edge_idx_t              k_r, k_nxt;
  logic [STW-1:0]         step_r, step_nxt;
  logic [NW-1:0]          acc_r, acc_nxt, acc_new;
  logic [SW-1:0]          rem_r, rem_nxt, rem_new;
  logic [JOB_W-1:0]       job_r, job_nxt;
  logic [FRAC_OUT_W-1:0]  frac_r [N_EDGES];
  logic [FRAC_OUT_W-1:0]  frac_nxt [N_EDGES];
  logic                   ov_r, ov_nxt;
  logic [OUT_DATA_W-1:0]  od_r, od_nxt;
  logic                   ou_r, ou_nxt;

  logic           j_any;
  logic [PWW-1:0] j_min_c, j_max_c;
  logic [PWH-1:0] j_min_r, j_max_r;
  logic [SWW-1:0] j_w;
  logic [SWH-1:0] j_h;
  logic [PW-1:0]  pos_sel;
  logic [SW-1:0]  div_sel;
  logic [SW:0]    rem_sh, rem_sub;
  logic           ge;

  assign {j_any, j_min_c, j_max_c, j_min_r, j_max_r, j_w, j_h} = job_r;

  always_comb begin
    unique case (k_r)
      EDGE_LEFT:   pos_sel = PW'(j_min_c);
      EDGE_RIGHT:  pos_sel = PW'(j_max_c);
      EDGE_TOP:    pos_sel = PW'(j_min_r);
      EDGE_BOTTOM: pos_sel = PW'(j_max_r);
      default:     pos_sel = '0;
    endcase
    div_sel = (k_r == EDGE_LEFT || k_r == EDGE_RIGHT) ? SW'(j_w) : SW'(j_h);
  end

  // one restoring step: quotient bits shift in where numerator bits leave
  assign rem_sh  = {rem_r, acc_r[NW-1]};
  assign rem_sub = rem_sh - {1'b0, div_sel};
  assign ge      = rem_sh >= {1'b0, div_sel};
  assign rem_new = ge ? rem_sub[SW-1:0] : rem_sh[SW-1:0];
  assign acc_new = {acc_r[NW-2:0], ge};

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    step_nxt  = step_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    job_nxt   = job_r;
    frac_nxt  = frac_r;
    q_rd      = 1'b0;
    ov_nxt    = ov_r && !out_tready;
    od_nxt    = od_r;
    ou_nxt    = ou_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          q_rd      = 1'b1;
          job_nxt   = q_data;
          k_nxt     = EDGE_LEFT;
          state_nxt = q_data[JOB_W-1] ? ST_LOAD : ST_DONE;
        end
      end
      ST_LOAD: begin
        acc_nxt   = {pos_sel, {FRAC_BITS{1'b0}}};
        rem_nxt   = '0;
        step_nxt  = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        acc_nxt  = acc_new;
        rem_nxt  = rem_new;
        step_nxt = step_r + 1'b1;
        if (step_r == STW'(NW - 1)) begin
          frac_nxt[k_r] = FRAC_OUT_W'(acc_new);
          if (k_r == EDGE_BOTTOM) begin
            state_nxt = ST_DONE;
          end else begin
            k_nxt     = edge_idx_t'(k_r + 2'd1);
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_DONE: begin
        // empty frame keeps the stored fractions
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1;
          for (int i = 0; i < N_EDGES; i++) begin
            od_nxt[i*FRAC_OUT_W +: FRAC_OUT_W] = frac_r[i];
          end
          ou_nxt    = j_any;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
    job_r  <= job_nxt;
    od_r   <= od_nxt;
    ou_r   <= ou_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= EDGE_LEFT;
      ov_r    <= 1'b0;
      for (int i = 0; i < N_EDGES; i++) frac_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      ov_r    <= ov_nxt;
      frac_r  <= frac_nxt;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;

endmodule

>>> rtl/core/bright_pixel_bounding_box_top.sv
// Top level of the bright pixel bounding box: register file, front, queue, back
// Throughput: one pixel beat per cycle; in_tready drops only while both queue slots hold frames.
// Results: a single shared divider works out the edges in turn, one quotient bit a cycle, over
//   NW = clog2(max(MAX_WIDTH, MAX_HEIGHT)) + FRAC_BITS bits; an out_tready stall holds the result beat.
// Reset: synchronous, active low; 640 x 480, threshold 128, tracking cleared, fractions zero.
module bright_pixel_bounding_box_top #(
  parameter int MAX_WIDTH  = bpbb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bpbb_pkg::DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = bpbb_pkg::DEF_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // pixel stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [bpbb_pkg::PIX_W-1:0]       in_tdata,   // [7:0] pixel
  input  logic [0:0]                       in_tuser,   // [0] frame_start
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [15:0] left_frac, [31:16] right_frac, [47:32] top_frac, [63:48] bottom_frac
  output logic [bpbb_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [0:0]                       out_tuser,  // [0] found
  // register port
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [bpbb_pkg::CFG_AW-1:0]      cfg_paddr,
  input  logic [bpbb_pkg::CFG_DW-1:0]      cfg_pwdata,
  output logic [bpbb_pkg::CFG_DW-1:0]      cfg_prdata,
  output logic                             cfg_pready
);
  import bpbb_pkg::*;

  localparam int PWW   = $clog2(MAX_WIDTH);
  localparam int PWH   = $clog2(MAX_HEIGHT);
  localparam int SWW   = $clog2(MAX_WIDTH + 1);
  localparam int SWH   = $clog2(MAX_HEIGHT + 1);
  localparam int JOB_W = 1 + 2 * PWW + 2 * PWH + SWW + SWH;

  logic [CFG_SIZE_W-1:0] width_r, width_nxt, height_r, height_nxt;
  logic [CFG_THR_W-1:0]  thresh_r, thresh_nxt;
  logic                  cfg_wr;
  reg_idx_t              cfg_idx;

  q_stat_t               q_stat;
  logic                  job_wr, q_rd;
  logic [JOB_W-1:0]      job_data, q_data;

  // register map: word index from paddr[3:2], byte bits ignored
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    thresh_nxt = thresh_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        REG_WIDTH:  width_nxt  = cfg_pwdata[CFG_SIZE_W-1:0];
        REG_HEIGHT: height_nxt = cfg_pwdata[CFG_SIZE_W-1:0];
        REG_THRESH: thresh_nxt = cfg_pwdata[CFG_THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_WIDTH:  cfg_prdata = CFG_DW'(width_r);
      REG_HEIGHT: cfg_prdata = CFG_DW'(height_r);
      REG_THRESH: cfg_prdata = CFG_DW'(thresh_r);
      default:    cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
      thresh_r <= RST_THRESH;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      thresh_r <= thresh_nxt;
    end
  end

  // front: position, threshold, box; pushes one job per frame
  bpbb_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_pixel   (in_tdata),
    .in_start   (in_tuser[0]),
    .cfg_width  (width_r),
    .cfg_height (height_r),
    .cfg_thresh (thresh_r),
    .q_stat     (q_stat),
    .job_wr     (job_wr),
    .job_data   (job_data)
  );

  // two-slot queue lets pixels keep flowing while the divider works
  bpbb_queue #(
    .DW (JOB_W)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (job_wr),
    .wr_data (job_data),
    .rd_en   (q_rd),
    .rd_data (q_data),
    .stat    (q_stat)
  );

  // back: a division for each box edge (skipped for an empty frame), then the result beat
  bpbb_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_data     (q_data),
    .q_rd       (q_rd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

>>> rtl/core/bpbb_checker.sv
// Port-level checks of the bright pixel bounding box, bound to the top level
`include "assert_macros.svh"

module bpbb_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [bpbb_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic [0:0]                       out_tuser,
  input logic                             cfg_psel,
  input logic                             cfg_penable,
  input logic                             cfg_pwrite,
  input logic [bpbb_pkg::CFG_AW-1:0]      cfg_paddr,
  input logic [bpbb_pkg::CFG_DW-1:0]      cfg_pwdata,
  input logic [bpbb_pkg::CFG_DW-1:0]      cfg_prdata,
  input logic                             cfg_pready
);
  import bpbb_pkg::*;

  // fractions of the last result beat; zero after reset like the design
  logic [OUT_DATA_W-1:0] last_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_data_r <= '0;
    end else if (out_tvalid && out_tready) begin
      last_data_r <= out_tdata;
    end
  end

  `BPBB_ASSERT_CLK(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result beat changed while stalled")
  `BPBB_ASSERT_RST(a_rst_quiet, !rst_n |=> !out_tvalid, "result valid right after reset")
  `BPBB_ASSERT_CLK(a_repeat, out_tvalid && !out_tuser[0] |-> out_tdata == last_data_r, "empty frame did not repeat fractions")
  `BPBB_ASSERT_CLK(a_width_rd, cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr[3:2] == REG_WIDTH |=> cfg_paddr[3:2] != REG_WIDTH || cfg_prdata[12:0] == $past(cfg_pwdata[12:0]), "width readback mismatch")

endmodule

bind bright_pixel_bounding_box_top bpbb_checker u_bpbb_checker (.*);
